[sv/fl64_pkg.sv]
// ----------------------------------------------------------------------------
// fl64_pkg: shared types, constants and arithmetic for the Fletcher-64 checker
// Holds the modulus, the word position codes, the modular add and the
// structs that pass between the top level and the accumulator core.
// ----------------------------------------------------------------------------
`default_nettype none

package fl64_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CheckW = 64;

  // Modulus 2^32-1; sums are kept in 0 .. ModValue-1.
  localparam logic [WordW-1:0] ModValue = {WordW{1'b1}};

  // Word position within a block; the first two words carry the stored check.
  localparam logic [1:0] PosHdrLo = 2'd0;
  localparam logic [1:0] PosHdrHi = 2'd1;
  localparam logic [1:0] PosSum   = 2'd2;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [CheckW-1:0] check_t;

  // One word handed to the core, with the strobe that commits it.
  typedef struct packed {
    logic  adv;
    logic  last;
    word_t word;
  } step_t;

  // Result of a block, valid on the step that carries the last word.
  typedef struct packed {
    check_t check_value;
    logic   matches_stored;
  } result_t;

  // Add modulo 2^32-1 with one conditional subtract; inputs are below the modulus.
  function automatic word_t add_mod(input word_t a, input word_t b);
    logic [WordW:0] s;
    logic [WordW:0] s_red;
    s     = {1'b0, a} + {1'b0, b};
    s_red = s - {1'b0, ModValue};
    if (s >= {1'b0, ModValue}) begin
      add_mod = s_red[WordW-1:0];
    end else begin
      add_mod = s[WordW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[sv/fl64_core.sv]
// ----------------------------------------------------------------------------
// fl64_core: running Fletcher-64 sums and stored check capture
// Keeps both sums, the stored check and the word position; works out the
// check value and match flag for the word on its input in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fl64_core
  import fl64_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire step_t   step,
  output result_t      res,
  output logic [1:0]   word_pos
);

  word_t      first_sum;
  word_t      second_sum;
  check_t     stored_check;
  logic [1:0] pos;

  word_t      fs_add;
  word_t      ss_add;
  word_t      first_sum_next;
  word_t      second_sum_next;
  check_t     stored_check_next;
  logic [1:0] pos_next;
  word_t      low_half;
  check_t     value;

  always_comb begin
    fs_add            = add_mod(first_sum, step.word);
    ss_add            = add_mod(second_sum, fs_add);
    first_sum_next    = first_sum;
    second_sum_next   = second_sum;
    stored_check_next = stored_check;
    pos_next          = pos;
    case (pos)
      PosHdrLo: begin
        stored_check_next = {{WordW{1'b0}}, step.word};
        pos_next          = PosHdrHi;
      end
      PosHdrHi: begin
        stored_check_next = {step.word, stored_check[WordW-1:0]};
        pos_next          = PosSum;
      end
      PosSum: begin
        first_sum_next  = fs_add;
        second_sum_next = ss_add;
      end
      default: begin
        pos_next = PosSum;
      end
    endcase
    // ModValue minus a value below it is its bitwise complement
    low_half           = ~add_mod(first_sum_next, second_sum_next);
    value              = {second_sum_next, low_half};
    res.check_value    = value;
    res.matches_stored = (value == stored_check_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sum    <= '0;
      second_sum   <= '0;
      stored_check <= '0;
      pos          <= PosHdrLo;
    end else if (step.adv) begin
      stored_check <= stored_check_next;
      if (step.last) begin
        first_sum  <= '0;
        second_sum <= '0;
        pos        <= PosHdrLo;
      end else begin
        first_sum  <= first_sum_next;
        second_sum <= second_sum_next;
        pos        <= pos_next;
      end
    end
  end

  assign word_pos = pos;

endmodule

`default_nettype wire

[sv/fletcher64_block_checksum.sv]
// ----------------------------------------------------------------------------
// fletcher64_block_checksum: Fletcher-64 metadata block checksum checker
// Streams a block as 32-bit words, captures the stored check from words 0
// and 1, sums the rest modulo 2^32-1 and reports the computed check value
// and whether it matches the stored one on the block's last word.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                 | tlast      | tuser
//  ---------+-----------+-----------------------+------------+----------------
//  s_axis   | in        | [31:0] data_word      | last_word  | -
//  m_axis   | out       | [63:0] check_value    | (none)     | [0] matches_stored
//
// One word per cycle sustained while no last word waits behind a blocked
// result. A word is captured in the input register, then the accumulator core
// updates both sums (two chained mod 2^32-1 adds) and, on the last word, the
// result register loads one result transaction, so the last word passes the
// input register and then the result register before its result can be taken.
// Reset (rst, synchronous) clears the sums, word position and both valids.
// A stalled result blocks only a last word waiting behind it; other words
// keep flowing into the sums.
`default_nettype none

module fletcher64_block_checksum
  import fl64_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] data_word
  input  wire logic        s_axis_tlast,  // last_word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [63:0] check_value
  output logic [0:0]       m_axis_tuser   // [0] matches_stored
);

  // Input register
  logic       in_valid;
  logic       in_last;
  word_t      in_word;

  // Result register
  logic       out_valid;
  check_t     out_value;
  logic       out_match;

  logic       out_free;
  logic       in_adv;
  logic       out_load;
  step_t      step;
  result_t    res;
  logic [1:0] word_pos;

  // A non-last word never needs the result register; a last word waits for it.
  assign out_free      = !out_valid || m_axis_tready;
  assign in_adv        = in_valid && (!in_last || out_free);
  assign out_load      = in_adv && in_last;
  assign s_axis_tready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Payload: load on every accepted transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  assign step.adv  = in_adv;
  assign step.last = in_last;
  assign step.word = in_word;

  fl64_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .res      (res),
    .word_pos (word_pos)
  );

  // Result register: load on a last word, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= res.check_value;
      out_match <= res.matches_stored;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_value;
  assign m_axis_tuser[0] = out_match;

  // Input side stalls only for a last word held behind a blocked result.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && in_last && out_valid && !m_axis_tready))
    else $error("input stalled without a blocked last word");

  // A new result appears only after a last word left the input register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_valid && in_last))
    else $error("result raised without a last word");

  // After a last word the next block starts at the stored-check words.
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> (word_pos == PosHdrLo))
    else $error("word position not restarted after last word");

  // Position saturates at the summing position.
  assert property (@(posedge clk) disable iff (rst)
    (word_pos == PosHdrLo) || (word_pos == PosHdrHi) || (word_pos == PosSum))
    else $error("word position out of range");

endmodule

`default_nettype wire

[tb/fletcher64_block_checksum_tb.sv]
// ----------------------------------------------------------------------------
// fletcher64_block_checksum_tb: self-checking bench for the Fletcher-64 checker
// Streams metadata blocks of many lengths and word patterns, some with a
// correct stored check and some without, and compares every result against
// a software copy of the two mod 2^32-1 running sums.
// ----------------------------------------------------------------------------
`default_nettype none

import fl64_pkg::*;

typedef enum int unsigned {
  FillRandom,
  FillOnes,
  FillZeros,
  FillNearMod,
  FillMixed
} fill_e;

typedef enum int unsigned {
  HdrGood,
  HdrRandom,
  HdrZero,
  HdrOnes
} hdr_e;

// Sum of two residues modulo 2^32-1.
function automatic word_t fold_add(input word_t a, input word_t b);
  logic [WordW:0] total;
  total = a + b;
  if (total >= ModValue) begin
    total = total - ModValue;
  end
  return total[WordW-1:0];
endfunction

class fl64_scoreboard;
  word_t       sum_a;
  word_t       sum_b;
  check_t      stored;
  logic [1:0]  pos;
  result_t     expected_q[$];
  int unsigned errors;
  int unsigned words_seen;
  int unsigned blocks_seen;
  int unsigned matches_seen;
  int unsigned results_checked;

  function new();
    sum_a  = '0;
    sum_b  = '0;
    stored = '0;
    pos    = PosHdrLo;
  endfunction

  task report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Track one accepted input word; queue the block result on the last word.
  function void note_word(input word_t w, input logic last);
    result_t r;
    words_seen++;
    case (pos)
      PosHdrLo: begin
        stored = {32'h0, w};
      end
      PosHdrHi: begin
        stored[63:32] = w;
      end
      default: begin
        sum_a = fold_add(sum_a, w);
        sum_b = fold_add(sum_b, sum_a);
      end
    endcase
    if (pos != PosSum) begin
      pos = pos + 2'd1;
    end
    if (last) begin
      r.check_value    = {sum_b, ModValue - fold_add(sum_a, sum_b)};
      r.matches_stored = (r.check_value == stored);
      expected_q.push_back(r);
      blocks_seen++;
      if (r.matches_stored) begin
        matches_seen++;
      end
      sum_a = '0;
      sum_b = '0;
      pos   = PosHdrLo;
    end
  endfunction

  task check_result(input check_t value, input logic flag);
    result_t want;
    results_checked++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %016h with no block pending", value));
      return;
    end
    want = expected_q.pop_front();
    if (value !== want.check_value) begin
      report($sformatf("check_value %016h, want %016h", value, want.check_value));
    end
    if (flag !== want.matches_stored) begin
      report($sformatf("matches_stored %0b, want %0b (value %016h)",
                       flag, want.matches_stored, want.check_value));
    end
  endtask
endclass

module fletcher64_block_checksum_tb;

  localparam int unsigned TargetWords = 1850;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  fl64_scoreboard sb;
  int unsigned    cycles;
  int unsigned    sent_words;
  int unsigned    hold_left;
  bit             calm;

  fletcher64_block_checksum i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] data_word
    .s_axis_tlast  (s_axis_tlast),   // last_word
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [63:0] check_value
    .m_axis_tuser  (m_axis_tuser)    // [0] matches_stored
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: end the run if the bench hangs on a handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.expected_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Monitor: sample both channels at the rising edge. Note the input
  // transaction first so a result can never overtake its own block.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_word(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      end
    end
  end

  // Result sink: hold off when asked, otherwise drop ready about 14% of the time.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 14);
      end
    end
  end

  // Offer one word; enter and leave at a falling edge. Random gaps go in
  // front of the word so valid is never dropped and raised in one step.
  task automatic send_word(input word_t w, input logic last);
    while (!calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  <= w;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    sent_words++;
    @(negedge clk);
  endtask

  // Build one block: header words, then payload words with the chosen fill.
  // The correct check is worked out on the fly so a good header can be sent.
  task automatic send_block(input int unsigned n_words, input fill_e fill,
                            input hdr_e hdr);
    word_t  payload[$];
    word_t  s1;
    word_t  s2;
    word_t  w;
    check_t chk;
    check_t head;
    int     i;
    s1 = '0;
    s2 = '0;
    for (i = 2; i < int'(n_words); i++) begin
      case (fill)
        FillOnes: begin
          w = 32'hFFFF_FFFF;
        end
        FillZeros: begin
          w = 32'h0;
        end
        FillNearMod: begin
          w = 32'hFFFF_FFFE;
        end
        FillMixed: begin
          case ($urandom_range(7))
            0: w = 32'h0;
            1: w = 32'hFFFF_FFFF;
            2: w = 32'hFFFF_FFFE;
            3: w = 32'h1 << $urandom_range(31);
            default: w = $urandom;
          endcase
        end
        default: begin
          w = $urandom;
        end
      endcase
      payload.push_back(w);
      s1 = fold_add(s1, w);
      s2 = fold_add(s2, s1);
    end
    chk = {s2, ModValue - fold_add(s1, s2)};
    case (hdr)
      HdrGood:   head = chk;
      HdrZero:   head = '0;
      HdrOnes:   head = '1;
      default:   head = {$urandom, $urandom};
    endcase
    send_word(head[31:0], n_words == 1);
    if (n_words >= 2) begin
      send_word(head[63:32], n_words == 2);
    end
    foreach (payload[k]) begin
      send_word(payload[k], k == payload.size() - 1);
    end
  endtask

  // Mostly well-formed blocks of short to medium length, a few long runs and
  // a few one- or two-word blocks; about half carry the correct check.
  task automatic run_random(input int unsigned until_words);
    int unsigned pick;
    int unsigned len;
    hdr_e        hdr;
    while (sent_words < until_words) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        len = $urandom_range(2, 1);
      end else if (pick < 94) begin
        len = $urandom_range(20, 3);
      end else begin
        len = $urandom_range(64, 21);
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        hdr = HdrGood;
      end else if (pick < 90) begin
        hdr = HdrRandom;
      end else if (pick < 95) begin
        hdr = HdrZero;
      end else begin
        hdr = HdrOnes;
      end
      send_block(len, fill_e'($urandom_range(4)), hdr);
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cycles        = 0;
    sent_words    = 0;
    hold_left     = 0;
    calm          = 1'b0;
    sb            = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: one- and two-word blocks with and without a match, all-ones
    // and all-zero payloads, payloads just below the modulus, extreme headers.
    send_block(1, FillZeros,   HdrZero);
    send_block(1, FillZeros,   HdrGood);
    send_block(2, FillZeros,   HdrGood);
    send_block(2, FillZeros,   HdrOnes);
    send_block(3, FillOnes,    HdrGood);
    send_block(3, FillZeros,   HdrGood);
    send_block(4, FillNearMod, HdrRandom);
    send_block(5, FillOnes,    HdrZero);
    send_block(3, FillRandom,  HdrOnes);

    // Random with gaps on both sides.
    run_random(650);

    // Back-to-back stretch: no idling on either side.
    calm = 1'b1;
    run_random(950);
    calm = 1'b0;

    // Hold off the sink while the source keeps offering, so the block fills
    // and stalls its input.
    hold_left = HoldCycles;
    run_random(1150);

    // Pause the source until every pending result has drained.
    s_axis_tvalid <= 1'b0;
    wait_drained();
    @(negedge clk);

    run_random(TargetWords);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Ran %0d words in %0d blocks, %0d of them with a matching stored check.",
             sb.words_seen, sb.blocks_seen, sb.matches_seen);
    $display("Compared %0d results, %0d mismatches, %0d cycles.",
             sb.results_checked, sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
